@@ rtl/core/scp_pkg.sv @@
package scp_pkg;

  localparam int MAX_PMUS = 4;
  localparam int PMU_W    = 2;

  localparam logic [2:0] CFG_PMU_COUNT         = 3'd0;
  localparam logic [2:0] CFG_HEADER_PRESENT    = 3'd1;
  localparam logic [2:0] CFG_PHASOR_FLOAT_MASK = 3'd2;
  localparam logic [2:0] CFG_ANALOG_FLOAT_MASK = 3'd3;
  localparam logic [2:0] CFG_FREQ_FLOAT_MASK   = 3'd4;
  localparam logic [2:0] CFG_PHASOR_COUNTS     = 3'd5;
  localparam logic [2:0] CFG_ANALOG_COUNTS     = 3'd6;
  localparam logic [2:0] CFG_STATUS_COUNTS     = 3'd7;

  typedef enum logic [3:0] {
    SEC_SIZE    = 4'd0,
    SEC_ID      = 4'd1,
    SEC_SOC     = 4'd2,
    SEC_FRAC    = 4'd3,
    SEC_STAT    = 4'd4,
    SEC_REAL    = 4'd5,
    SEC_IMAG    = 4'd6,
    SEC_ANALOG  = 4'd7,
    SEC_FREQ    = 4'd8,
    SEC_ROCOF   = 4'd9,
    SEC_DIGITAL = 4'd10,
    SEC_CRC     = 4'd11
  } section_t;

  typedef struct packed {
    section_t          section;
    logic [PMU_W-1:0]  pmu;
    logic [15:0]       elem;
    logic              done;
  } pstate_t;

  typedef struct packed {
    logic [2:0]  pmu_count;
    logic        header_present;
    logic [3:0]  phasor_float_mask;
    logic [3:0]  analog_float_mask;
    logic [3:0]  freq_float_mask;
    logic [63:0] phasor_counts;
    logic [63:0] analog_counts;
    logic [63:0] status_counts;
  } cfg_t;

  function automatic logic [15:0] count_of(logic [63:0] r, logic [PMU_W-1:0] p);
    return r[{p, 4'b0000} +: 16];
  endfunction

  function automatic logic [2:0] pmus_in_frame(logic [2:0] n);
    return (n > 3'(MAX_PMUS)) ? 3'(MAX_PMUS) : n;
  endfunction

  function automatic logic field_wide(section_t s, logic [PMU_W-1:0] p, cfg_t c);
    logic w;
    w = 1'b0;
    case (s) inside
      SEC_SOC, SEC_FRAC:  w = 1'b1;
      SEC_REAL, SEC_IMAG: w = c.phasor_float_mask[p];
      SEC_ANALOG:         w = c.analog_float_mask[p];
      SEC_FREQ, SEC_ROCOF: w = c.freq_float_mask[p];
      default:            w = 1'b0;
    endcase
    return w;
  endfunction

  function automatic pstate_t enter_pmu(logic [2:0] p, cfg_t c);
    pstate_t r;
    r.elem = '0;
    r.done = 1'b0;
    if (p >= pmus_in_frame(c.pmu_count)) begin
      r.pmu     = '0;
      r.section = c.header_present ? SEC_CRC : SEC_DIGITAL;
      r.done    = !c.header_present;
    end else begin
      r.pmu     = p[PMU_W-1:0];
      r.section = c.header_present ? SEC_STAT : SEC_REAL;
    end
    return r;
  endfunction

  // Empty lists are passed over: digital words first, since leaving them can
  // land on the phasors of the next PMU, which can in turn be empty.
  function automatic pstate_t skip_empty(pstate_t s, cfg_t c);
    pstate_t r;
    r = s;
    if (!r.done && r.section == SEC_DIGITAL &&
        r.elem >= count_of(c.status_counts, r.pmu)) begin
      r = enter_pmu({1'b0, r.pmu} + 3'd1, c);
    end
    if (!r.done && r.section == SEC_REAL &&
        r.elem >= count_of(c.phasor_counts, r.pmu)) begin
      r.section = SEC_ANALOG;
      r.elem    = '0;
    end
    if (!r.done && r.section == SEC_ANALOG &&
        r.elem >= count_of(c.analog_counts, r.pmu)) begin
      r.section = SEC_FREQ;
      r.elem    = '0;
    end
    return r;
  endfunction

  function automatic pstate_t advance(pstate_t s, cfg_t c);
    pstate_t     r;
    logic [16:0] nxt;
    r   = s;
    nxt = {1'b0, s.elem} + 17'd1;
    unique case (s.section)
      SEC_SIZE:  r.section = SEC_ID;
      SEC_ID:    r.section = SEC_SOC;
      SEC_SOC:   r.section = SEC_FRAC;
      SEC_FRAC:  r = enter_pmu(3'd0, c);
      SEC_STAT: begin
        r.section = SEC_REAL;
        r.elem    = '0;
      end
      SEC_REAL:  r.section = SEC_IMAG;
      SEC_IMAG: begin
        if (nxt < {1'b0, count_of(c.phasor_counts, s.pmu)}) begin
          r.section = SEC_REAL;
          r.elem    = nxt[15:0];
        end else begin
          r.section = SEC_ANALOG;
          r.elem    = '0;
        end
      end
      SEC_ANALOG: begin
        if (nxt < {1'b0, count_of(c.analog_counts, s.pmu)}) begin
          r.elem = nxt[15:0];
        end else begin
          r.section = SEC_FREQ;
          r.elem    = '0;
        end
      end
      SEC_FREQ:  r.section = SEC_ROCOF;
      SEC_ROCOF: begin
        r.section = SEC_DIGITAL;
        r.elem    = '0;
      end
      SEC_DIGITAL: begin
        if (nxt < {1'b0, count_of(c.status_counts, s.pmu)}) begin
          r.elem = nxt[15:0];
        end else begin
          r = enter_pmu({1'b0, s.pmu} + 3'd1, c);
        end
      end
      default:   r.done = 1'b1;
    endcase
    return skip_empty(r, c);
  endfunction

endpackage

@@ rtl/core/scp_ifs.sv @@
interface scp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface scp_field_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [1:0]  pmu_number;
  logic [15:0] element_index;
  logic [31:0] field_value;
  logic        frame_last;

  modport source (output valid, output field_kind, output pmu_number,
                  output element_index, output field_value, output frame_last,
                  input ready);
  modport sink (input valid, input field_kind, input pmu_number,
                input element_index, input field_value, input frame_last,
                output ready);
endinterface

interface scp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/scp_regs.sv @@
module scp_regs import scp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  scp_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pmu_count         <= 3'd1;
      regs.header_present    <= 1'b1;
      regs.phasor_float_mask <= '0;
      regs.analog_float_mask <= '0;
      regs.freq_float_mask   <= '0;
      regs.phasor_counts     <= '0;
      regs.analog_counts     <= '0;
      regs.status_counts     <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_PMU_COUNT:         regs.pmu_count         <= cfg.data[2:0];
        CFG_HEADER_PRESENT:    regs.header_present    <= cfg.data[0];
        CFG_PHASOR_FLOAT_MASK: regs.phasor_float_mask <= cfg.data[3:0];
        CFG_ANALOG_FLOAT_MASK: regs.analog_float_mask <= cfg.data[3:0];
        CFG_FREQ_FLOAT_MASK:   regs.freq_float_mask   <= cfg.data[3:0];
        CFG_PHASOR_COUNTS:     regs.phasor_counts     <= cfg.data;
        CFG_ANALOG_COUNTS:     regs.analog_counts     <= cfg.data;
        CFG_STATUS_COUNTS:     regs.status_counts     <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/scp_engine.sv @@
module scp_engine import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        regs,
  scp_byte_if.sink    byte_in,
  scp_field_if.source field_out
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_start;

  section_t         section;
  logic [PMU_W-1:0] pmu_counter;
  logic [15:0]      element_counter;
  logic [1:0]       byte_counter;
  logic [31:0]      assembly;
  logic             frame_done;

  logic             fire;
  pstate_t          cur;
  pstate_t          st0;
  pstate_t          st_next;
  logic [1:0]       byte_base;
  logic [31:0]      asm_base;
  logic [31:0]      asm_new;
  logic             wide;
  logic             complete;
  logic             emit;
  logic [1:0]       byte_counter_next;
  logic [31:0]      assembly_next;
  logic             per_pmu;
  logic             indexed;

  assign fire          = in_valid && (!field_out.valid || field_out.ready);
  assign byte_in.ready = !rst && (!in_valid || fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte  <= byte_in.data_byte;
      in_start <= byte_in.frame_start;
    end
  end

  always_comb begin
    cur.section = section;
    cur.pmu     = pmu_counter;
    cur.elem    = element_counter;
    cur.done    = frame_done;

    st0       = cur;
    byte_base = byte_counter;
    asm_base  = assembly;
    if (in_start) begin
      byte_base = '0;
      asm_base  = '0;
      if (regs.header_present) begin
        st0.section = SEC_SIZE;
        st0.pmu     = '0;
        st0.elem    = '0;
        st0.done    = 1'b0;
      end else begin
        st0 = enter_pmu(3'd0, regs);
      end
      st0 = skip_empty(st0, regs);
    end

    asm_new  = {asm_base[23:0], in_byte};
    wide     = field_wide(st0.section, st0.pmu, regs);
    complete = wide ? (byte_base == 2'd3) : (byte_base != 2'd0);
    emit     = !st0.done && complete;

    st_next           = st0;
    byte_counter_next = byte_base;
    assembly_next     = asm_base;
    if (!st0.done) begin
      if (complete) begin
        st_next           = advance(st0, regs);
        byte_counter_next = '0;
        assembly_next     = '0;
      end else begin
        byte_counter_next = byte_base + 2'd1;
        assembly_next     = asm_new;
      end
    end

    per_pmu = st0.section inside {[SEC_STAT:SEC_DIGITAL]};
    indexed = st0.section inside {SEC_REAL, SEC_IMAG, SEC_ANALOG, SEC_DIGITAL};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section         <= SEC_SIZE;
      pmu_counter     <= '0;
      element_counter <= '0;
      byte_counter    <= '0;
      assembly        <= '0;
      frame_done      <= 1'b1;
    end else if (fire) begin
      section         <= st_next.section;
      pmu_counter     <= st_next.pmu;
      element_counter <= st_next.elem;
      byte_counter    <= byte_counter_next;
      assembly        <= assembly_next;
      frame_done      <= st_next.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_out.valid <= 1'b0;
    end else if (fire) begin
      field_out.valid <= emit;
    end else if (field_out.ready) begin
      field_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      field_out.field_kind    <= st0.section;
      field_out.pmu_number    <= per_pmu ? st0.pmu : '0;
      field_out.element_index <= indexed ? st0.elem : '0;
      field_out.field_value   <= wide ? asm_new : {16'h0000, asm_new[15:0]};
      field_out.frame_last    <= st_next.done;
    end
  end

endmodule

@@ rtl/core/synchrophasor_data_frame_parser_core.sv @@
// Channel     Direction  Beat contents
// byte_in     in         data_byte, frame_start
// field_out   out        field_kind, pmu_number, element_index, field_value, frame_last
// cfg         in         index, data (register write)
//
// One byte is taken per cycle while field_out does not stall; a field's last
// byte goes to the byte register, then the field register. Each holds one beat,
// so a new byte is taken while a finished field waits. When field_out stalls with
// a byte held, byte_in drops ready. Reset is synchronous; ready is low during it.
module synchrophasor_data_frame_parser_core import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  scp_byte_if.sink    byte_in,
  scp_field_if.source field_out,
  scp_cfg_if.sink     cfg
);

  cfg_t regs;

  scp_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  scp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .byte_in   (byte_in),
    .field_out (field_out)
  );

endmodule

@@ rtl/core/scp_checker.sv @@
module scp_checker import scp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  field_kind,
  input logic [1:0]  pmu_number,
  input logic [15:0] element_index,
  input logic [31:0] field_value,
  input logic        frame_last
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("field_out valid after reset");

  a_out_follows_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("field appeared without a byte two cycles earlier");

  a_header_pmu_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (field_kind == SEC_SIZE || field_kind == SEC_ID ||
                  field_kind == SEC_SOC || field_kind == SEC_FRAC ||
                  field_kind == SEC_CRC) |-> pmu_number == 2'd0)
    else $error("header or crc field with nonzero PMU number");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(field_kind == SEC_REAL || field_kind == SEC_IMAG ||
                   field_kind == SEC_ANALOG || field_kind == SEC_DIGITAL)
    |-> element_index == 16'd0)
    else $error("unindexed field with nonzero element index");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(field_kind) &&
    $stable(pmu_number) && $stable(element_index) && $stable(field_value) &&
    $stable(frame_last))
    else $error("field beat changed while stalled");

endmodule

bind synchrophasor_data_frame_parser_core scp_checker u_scp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (byte_in.valid),
  .in_ready      (byte_in.ready),
  .out_valid     (field_out.valid),
  .out_ready     (field_out.ready),
  .field_kind    (field_out.field_kind),
  .pmu_number    (field_out.pmu_number),
  .element_index (field_out.element_index),
  .field_value   (field_out.field_value),
  .frame_last    (field_out.frame_last)
);
